### hw/rtl/nrt_pkg.sv
// shared types, widths and codes of the nonce replay table
package nrt_pkg;

   // pool size default and fixed field widths
   localparam int POOL_DEPTH_DEF = 8;
   localparam int TIME_W         = 32;
   localparam int NONCE_W        = 64;
   localparam int SLOT_W         = 6;
   localparam int CNT_W          = 7;
   localparam int STAT_W         = 2;
   localparam int REQ_DATA_W     = 168;
   localparam int REQ_USER_W     = 1;
   localparam int RSP_DATA_W     = 16;
   localparam int ENTRY_W        = TIME_W + 2 * NONCE_W;

   localparam logic [TIME_W-1:0] TTL_RESET = 32'd30000;

   // request kind carried in tuser
   typedef enum logic [REQ_USER_W-1:0] {
      CMD_ISSUE  = 1'b0,
      CMD_VERIFY = 1'b1
   } cmd_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_SIG   = 2'd1,
      STATUS_BAD_NONCE = 2'd2
   } status_type;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic step;
      logic commit;
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } dp_stat_type;

endpackage

### hw/rtl/nrt_ctrl.sv
// sequencer that steps one transaction through capture, slot scan and commit
module nrt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  nrt_pkg::dp_stat_type stat,
   output nrt_pkg::ctrl_cmd_type cmd
);
   import nrt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_EVAL   = 4'b0100,
      S_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // next state and command decode
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            if (stat.scan_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hw/rtl/nrt_dp.sv
// slot storage, scan evaluation, table update and result register
module nrt_dp #(
   parameter int POOL_DEPTH = nrt_pkg::POOL_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  nrt_pkg::ctrl_cmd_type         cmd,
   output nrt_pkg::dp_stat_type          stat,
   input  logic [nrt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [nrt_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                          csr_valid,
   input  logic [nrt_pkg::TIME_W-1:0]    csr_data,
   input  logic                          rsp_tready,
   output logic                          rsp_tvalid,
   output logic [nrt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import nrt_pkg::*;

   localparam int IDX_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_DEPTH - 1);

   // captured request
   cmd_type             req_cmd_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [NONCE_W-1:0]  hi_ff;
   logic [NONCE_W-1:0]  lo_ff;
   logic                hdr_ff, form_ff, sig_ff, mut_ff;

   // slot store and per-slot flags
   logic [ENTRY_W-1:0]    slot_mem_ff [POOL_DEPTH];
   logic [ENTRY_W-1:0]    mem_q_ff;
   logic [POOL_DEPTH-1:0] valid_ff, valid_in;
   logic [POOL_DEPTH-1:0] spent_ff, spent_in;
   logic [IDX_W-1:0]      evict_ff, evict_in;
   logic [TIME_W-1:0]     ttl_ff;

   // scan pointer and accumulators
   logic [IDX_W-1:0] addr_ff;
   logic             rd_vld_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             match_found_ff, match_found_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic [CNT_W-1:0] live_cnt_ff, live_cnt_in;

   // result register
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // evaluation of the slot read last cycle
   logic [TIME_W-1:0] age;
   logic              live, hit;

   // commit decisions
   logic             wr_en;
   logic [IDX_W-1:0] slot_sel;
   status_type       status;
   logic [SLOT_W-1:0] slot_out;
   logic [CNT_W-1:0]  cnt_out;

   assign stat.scan_last = (addr_ff == LAST_IDX);
   assign stat.out_free  = !rsp_vld_ff || rsp_tready;
   assign rsp_tvalid     = rsp_vld_ff;
   assign rsp_tdata      = rsp_data_ff;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff <= cmd_type'(req_tuser);
         now_ff     <= req_tdata[31:0];
         hi_ff      <= req_tdata[95:32];
         lo_ff      <= req_tdata[159:96];
         hdr_ff     <= req_tdata[160];
         form_ff    <= req_tdata[161];
         sig_ff     <= req_tdata[162];
         mut_ff     <= req_tdata[163];
      end
   end

   // ttl register
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= TTL_RESET;
      end else if (csr_valid) begin
         ttl_ff <= csr_data;
      end
   end

   // scan address and read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.step;
         if (cmd.capture) begin
            addr_ff <= '0;
         end else if (cmd.step) begin
            addr_ff <= addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
   end

   // slot memory: one read port for the scan, one write port for issue
   always_ff @(posedge clock) begin
      if (cmd.step) begin
         mem_q_ff <= slot_mem_ff[addr_ff];
      end
      if (wr_en) begin
         slot_mem_ff[slot_sel] <= {now_ff, hi_ff, lo_ff};
      end
   end

   // liveness and lookup of the slot just read
   always_comb begin
      age  = now_ff - mem_q_ff[ENTRY_W-1 -: TIME_W];
      live = valid_ff[rd_idx_ff] && !(age > ttl_ff);
      hit  = live && hdr_ff && form_ff
             && (mem_q_ff[2*NONCE_W-1 -: NONCE_W] == hi_ff)
             && (mem_q_ff[NONCE_W-1:0] == lo_ff);
   end

   // scan accumulators: first free slot, first match, live count
   always_comb begin
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      live_cnt_in    = live_cnt_ff;
      if (cmd.capture) begin
         free_found_in  = 1'b0;
         match_found_in = 1'b0;
         live_cnt_in    = '0;
      end else if (rd_vld_ff) begin
         if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
         if (hit && !match_found_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = rd_idx_ff;
         end
         if (live) begin
            live_cnt_in = live_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         live_cnt_ff    <= '0;
      end else begin
         free_found_ff  <= free_found_in;
         match_found_ff <= match_found_in;
         live_cnt_ff    <= live_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      free_idx_ff  <= free_idx_in;
      match_idx_ff <= match_idx_in;
   end

   // commit: table update and result fields
   always_comb begin
      wr_en    = 1'b0;
      slot_sel = match_idx_ff;
      status   = STATUS_OK;
      slot_out = '0;
      cnt_out  = live_cnt_ff;
      valid_in = valid_ff;
      spent_in = spent_ff;
      evict_in = evict_ff;
      unique case (req_cmd_ff)
         CMD_ISSUE: begin
            slot_sel = free_found_ff ? free_idx_ff : evict_ff;
            slot_out = SLOT_W'(slot_sel);
            cnt_out  = live_cnt_ff + CNT_W'(free_found_ff);
            if (cmd.commit) begin
               wr_en              = 1'b1;
               valid_in[slot_sel] = 1'b1;
               spent_in[slot_sel] = 1'b0;
               if (!free_found_ff) begin
                  evict_in = (evict_ff == LAST_IDX) ? '0 : evict_ff + 1'b1;
               end
            end
         end
         CMD_VERIFY: begin
            if (!hdr_ff) begin
               status = STATUS_BAD_SIG;
            end else if (!form_ff || !match_found_ff) begin
               status = STATUS_BAD_NONCE;
            end else begin
               slot_out = SLOT_W'(match_idx_ff);
               if (!sig_ff) begin
                  status = STATUS_BAD_SIG;
               end else if (mut_ff) begin
                  if (spent_ff[match_idx_ff]) begin
                     status = STATUS_BAD_NONCE;
                  end else if (cmd.commit) begin
                     spent_in[match_idx_ff] = 1'b1;
                  end
               end
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         spent_ff <= '0;
         evict_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         spent_ff <= spent_in;
         evict_ff <= evict_in;
      end
   end

   // result register, loaded on commit and held until taken
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (cmd.commit) begin
         rsp_vld_in  = 1'b1;
         rsp_data_in = RSP_DATA_W'({cnt_out, slot_out, status});
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // a spent slot is always a written slot
   a_spent_valid: assert property (@(posedge clock) disable iff (reset)
      (spent_ff & ~valid_ff) == '0)
      else $error("spent flag set on a slot never issued");

   // live count stays within the pool
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= CNT_W'(POOL_DEPTH))
      else $error("live count beyond pool depth");

   // a lookup hit needs both format checks passed
   a_match_form: assert property (@(posedge clock) disable iff (reset)
      match_found_ff |-> (hdr_ff && form_ff))
      else $error("match recorded on malformed request");

   // commit never overwrites a pending result
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_vld_ff || rsp_tready))
      else $error("commit while result register busy");

   // a commit always presents a result next cycle
   a_commit_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_vld_ff)
      else $error("commit without result");

endmodule

### hw/rtl/nonce_replay_table.sv
// Nonce replay table top level: sequencer plus slot datapath.
// Each transaction scans the slot memory through its single read port, one slot per
// cycle, then is evaluated and committed before the next request is accepted.
// A new request is taken while the previous result waits in the output register.
// Reset: synchronous; clears slot valid and spent flags, evict pointer, ttl to 30000.
module nonce_replay_table #(
   parameter int POOL_DEPTH = nrt_pkg::POOL_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: now_ms[31:0], nonce_hi[95:32], nonce_lo[159:96], header_ok[160],
   //        nonce_form_ok[161], sig_match[162], mutating[163], zero pad[167:164]
   input  logic [nrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: cmd[0]
   input  logic [nrt_pkg::REQ_USER_W-1:0] req_tuser,
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: status[1:0], slot_used[7:2], live_count[14:8], zero pad[15]
   output logic [nrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // ttl register write
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [nrt_pkg::TIME_W-1:0]     csr_data
);
   import nrt_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ready = 1'b1;

   // controller
   nrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   nrt_dp #(
      .POOL_DEPTH (POOL_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### dv/tb.sv
// self-checking testbench of the nonce replay table: directed and random traffic
`timescale 1ns / 100ps

module tb;
   import nrt_pkg::*;

   localparam int DEPTH = POOL_DEPTH_DEF;

   // one request as the block sees it
   typedef struct {
      cmd_type           cmd;
      logic [TIME_W-1:0] now_ms;
      logic [63:0]       nonce_hi;
      logic [63:0]       nonce_lo;
      logic              header_ok;
      logic              form_ok;
      logic              sig_match;
      logic              mutating;
   } nonce_req_type;

   // one verdict as the block reports it
   typedef struct {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [CNT_W-1:0]  live;
   } nonce_verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [TIME_W-1:0]     csr_data;

   // predicted table contents
   logic              tbl_valid [DEPTH];
   logic              tbl_spent [DEPTH];
   logic [TIME_W-1:0] tbl_time [DEPTH];
   logic [63:0]       tbl_hi [DEPTH];
   logic [63:0]       tbl_lo [DEPTH];
   int                tbl_evict;
   logic [TIME_W-1:0] tbl_ttl;

   nonce_verdict_type pending_verdicts [$];
   logic [127:0]   recent_nonces [$];
   logic [TIME_W-1:0] req_clock_ms;
   bit req_idle_on;
   bit rsp_idle_on;
   int fail_count;
   int sent_count;
   int checked_count;
   int ttl_settings;

   nonce_replay_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // a slot is live while its wrapping age does not exceed the ttl
   function automatic bit slot_is_live(input int i, input logic [TIME_W-1:0] t);
      logic [TIME_W-1:0] age;
      age = t - tbl_time[i];
      return tbl_valid[i] && !(age > tbl_ttl);
   endfunction

   // advance the predicted table by one request and return its verdict
   function automatic nonce_verdict_type table_step(input nonce_req_type r);
      nonce_verdict_type v;
      int hit;
      int n;
      hit = -1;
      n = 0;
      v.status = STATUS_OK;
      v.slot = '0;
      if (r.cmd == CMD_ISSUE) begin
         for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && !slot_is_live(i, r.now_ms)) hit = i;
         // table full of live nonces: round-robin eviction
         if (hit < 0) begin
            hit = tbl_evict;
            tbl_evict = (tbl_evict + 1) % DEPTH;
         end
         tbl_hi[hit] = r.nonce_hi;
         tbl_lo[hit] = r.nonce_lo;
         tbl_time[hit] = r.now_ms;
         tbl_valid[hit] = 1'b1;
         tbl_spent[hit] = 1'b0;
         v.slot = SLOT_W'(hit);
      end else if (!r.header_ok) begin
         v.status = STATUS_BAD_SIG;
      end else if (!r.form_ok) begin
         v.status = STATUS_BAD_NONCE;
      end else begin
         // lowest live slot holding the nonce wins
         for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && slot_is_live(i, r.now_ms) && tbl_hi[i] == r.nonce_hi &&
                tbl_lo[i] == r.nonce_lo) hit = i;
         if (hit < 0) begin
            v.status = STATUS_BAD_NONCE;
         end else begin
            v.slot = SLOT_W'(hit);
            if (!r.sig_match) begin
               v.status = STATUS_BAD_SIG;
            end else if (r.mutating) begin
               if (tbl_spent[hit]) v.status = STATUS_BAD_NONCE;
               else tbl_spent[hit] = 1'b1;
            end
         end
      end
      for (int i = 0; i < DEPTH; i++)
         if (slot_is_live(i, r.now_ms)) n++;
      v.live = CNT_W'(n);
      return v;
   endfunction

   function automatic nonce_req_type make_req(input cmd_type c, input logic [TIME_W-1:0] t,
                                              input logic [127:0] nonce, input logic hdr,
                                              input logic form, input logic sig,
                                              input logic mut);
      nonce_req_type r;
      r.cmd = c;
      r.now_ms = t;
      r.nonce_hi = nonce[127:64];
      r.nonce_lo = nonce[63:0];
      r.header_ok = hdr;
      r.form_ok = form;
      r.sig_match = sig;
      r.mutating = mut;
      return r;
   endfunction

   function automatic logic [127:0] rand_nonce();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // drive one request and record its predicted verdict when the request is accepted
   task automatic send_req(input nonce_req_type r);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser = r.cmd;
      req_tdata = {4'b0, r.mutating, r.sig_match, r.form_ok, r.header_ok,
                   r.nonce_lo, r.nonce_hi, r.now_ms};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_verdicts.push_back(table_step(r));
      sent_count++;
   endtask

   // stop sending and let every outstanding verdict come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DEPTH + 4) @(posedge clock);
   endtask

   task automatic write_ttl(input logic [TIME_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_data = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tbl_ttl = value;
      ttl_settings++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random issue and verify traffic around the current ttl
   task automatic run_traffic(input int count);
      int span;
      logic [127:0] n;
      nonce_req_type r;
      span = (tbl_ttl > 40000) ? 5000 : int'(tbl_ttl / 6) + 1;
      for (int k = 0; k < count; k++) begin
         // change idling pattern now and then, sometimes none at all
         if (k % 64 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         // time mostly creeps forward, rarely jumps anywhere
         if ($urandom_range(0, 49) == 0) req_clock_ms = $urandom;
         else if ($urandom_range(0, 3) != 0) req_clock_ms += $urandom_range(0, span);
         if ($urandom_range(0, 99) < 35) begin
            if (recent_nonces.size() > 0 && $urandom_range(0, 9) == 0)
               n = recent_nonces[$urandom_range(0, recent_nonces.size() - 1)];
            else
               n = rand_nonce();
            r = make_req(CMD_ISSUE, req_clock_ms, n, 1'($urandom), 1'($urandom),
                         1'($urandom), 1'($urandom));
            recent_nonces.push_back(n);
            if (recent_nonces.size() > 12) void'(recent_nonces.pop_front());
         end else begin
            if (recent_nonces.size() > 0 && $urandom_range(0, 4) != 0)
               n = recent_nonces[$urandom_range(0, recent_nonces.size() - 1)];
            else
               n = rand_nonce();
            r = make_req(CMD_VERIFY, req_clock_ms, n, $urandom_range(0, 9) != 0,
                         $urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0,
                         1'($urandom_range(0, 1)));
         end
         send_req(r);
      end
   endtask

   // format checks, lookup, replay, duplicates, eviction, expiry edge and wrap
   task automatic test_directed_cases();
      logic [TIME_W-1:0] t0;
      logic [127:0] na;
      logic [127:0] nb;
      logic [127:0] nc;
      t0 = 32'h0000_1000;
      na = '1;
      nb = '0;
      nc = rand_nonce();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_req(make_req(CMD_VERIFY, t0, na, 1'b1, 1'b1, 1'b1, 1'b1));     // empty table
      send_req(make_req(CMD_ISSUE, t0, na, 1'b0, 1'b0, 1'b0, 1'b0));
      send_req(make_req(CMD_ISSUE, t0 + 1, nb, 1'b1, 1'b1, 1'b1, 1'b1));
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b0, 1'b1, 1'b1, 1'b1)); // bad header
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b1, 1'b0, 1'b1, 1'b1)); // bad nonce text
      send_req(make_req(CMD_VERIFY, t0 + 1, na, 1'b1, 1'b1, 1'b0, 1'b1)); // sig mismatch
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b1, 1'b1, 1'b1, 1'b0));
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b1, 1'b1, 1'b1, 1'b1)); // spend
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b1, 1'b1, 1'b1, 1'b1)); // replay
      send_req(make_req(CMD_VERIFY, t0 + 1, nb, 1'b1, 1'b1, 1'b1, 1'b0)); // spent ignored
      send_req(make_req(CMD_ISSUE, t0 + 2, na, 1'b1, 1'b0, 1'b1, 1'b0));  // duplicate nonce
      send_req(make_req(CMD_VERIFY, t0 + 2, na, 1'b1, 1'b1, 1'b1, 1'b1));
      // age equals ttl, then one past it
      send_req(make_req(CMD_VERIFY, t0 + TTL_RESET, na, 1'b1, 1'b1, 1'b1, 1'b1));
      send_req(make_req(CMD_VERIFY, t0 + TTL_RESET + 1, na, 1'b1, 1'b1, 1'b1, 1'b1));
      // fill the table, then force round-robin eviction
      repeat (DEPTH)
         send_req(make_req(CMD_ISSUE, t0 + TTL_RESET + 1, rand_nonce(),
                           1'b0, 1'b1, 1'b0, 1'b1));
      send_req(make_req(CMD_ISSUE, 32'hFFFF_FFF0, nc, 1'b1, 1'b1, 1'b1, 1'b1));
      send_req(make_req(CMD_VERIFY, 32'h0000_0010, nc, 1'b1, 1'b1, 1'b1, 1'b1)); // wrapped
      send_req(make_req(CMD_VERIFY, 32'h0000_0010,
                        {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA},
                        1'b1, 1'b1, 1'b1, 1'b0));
   endtask

   task automatic test_default_ttl();
      write_ttl(TTL_RESET);
      req_clock_ms = $urandom;
      run_traffic(300);
   endtask

   task automatic test_zero_ttl();
      write_ttl('0);
      req_clock_ms = $urandom;
      run_traffic(300);
   endtask

   task automatic test_max_ttl();
      write_ttl('1);
      req_clock_ms = $urandom;
      run_traffic(300);
   endtask

   task automatic test_short_ttl();
      write_ttl(32'd40);
      req_clock_ms = 32'hFFFF_F000;
      run_traffic(350);
   endtask

   task automatic test_random_ttl();
      repeat (3) begin
         write_ttl($urandom_range(1, 200000));
         req_clock_ms = $urandom;
         run_traffic(125);
      end
   endtask

   // response backpressure: a fresh random stall, when enabled, before every result
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 8) : 0;
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // compare each result transaction with the oldest predicted verdict
   initial begin
      nonce_verdict_type want;
      logic [STAT_W-1:0] got_status;
      logic [SLOT_W-1:0] got_slot;
      logic [CNT_W-1:0]  got_live;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_status = rsp_tdata[1:0];
            got_slot = rsp_tdata[7:2];
            got_live = rsp_tdata[14:8];
            checked_count++;
            if (pending_verdicts.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: status %0d slot %0d live %0d",
                           got_status, got_slot, got_live);
            end else begin
               want = pending_verdicts.pop_front();
               if (got_status !== want.status || got_slot !== want.slot ||
                   got_live !== want.live) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result %0d mismatch: status %0d/%0d slot %0d/%0d live %0d/%0d",
                              checked_count, want.status, got_status, want.slot, got_slot,
                              want.live, got_live);
               end
            end
         end
      end
   end

   // reset, test sequence and final verdict
   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = CMD_ISSUE;
      csr_valid = 1'b0;
      csr_data = '0;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      fail_count = 0;
      sent_count = 0;
      checked_count = 0;
      ttl_settings = 0;
      tbl_evict = 0;
      tbl_ttl = TTL_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_spent[i] = 1'b0;
         tbl_time[i] = '0;
         tbl_hi[i] = '0;
         tbl_lo[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_default_ttl();
      test_zero_ttl();
      test_max_ttl();
      test_short_ttl();
      test_random_ttl();
      wait_drained();

      $display("issue/verify traffic: %0d requests sent, %0d results checked", sent_count,
               checked_count);
      $display("ttl settings exercised: %0d (zero, max, short, default, random)",
               ttl_settings);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
